FILE: rtl/ggrd_pkg.sv
`default_nettype none

package ggrd_pkg;

   // sizes
   localparam int HISTORY_DEPTH = 10;
   localparam int GLUE_WIDTH    = 24;
   localparam int COUNT_WIDTH   = 48;
   localparam int MARGIN_WIDTH  = 18;
   localparam int MARGIN_FRAC   = 16;
   localparam int SLOT_WIDTH    = $clog2(HISTORY_DEPTH);
   localparam int FILL_WIDTH    = $clog2(HISTORY_DEPTH + 1);

   // internal arithmetic widths
   localparam int GRAD_WIDTH    = GLUE_WIDTH + 1;
   localparam int M2_WIDTH      = GLUE_WIDTH + 6;
   localparam int M2_MAG_WIDTH  = MARGIN_WIDTH + 1;
   localparam int PROD_WIDTH    = GLUE_WIDTH + M2_MAG_WIDTH;
   localparam int CSR_IDX_WIDTH = 2;

   // register reset values, Q2.16
   localparam logic [MARGIN_WIDTH-1:0] BASE_MARGIN_RESET = MARGIN_WIDTH'(68813);
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_MIN_RESET  = MARGIN_WIDTH'(52429);
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_MAX_RESET  = MARGIN_WIDTH'(163840);

   localparam logic [SLOT_WIDTH-1:0] LAST_SLOT  = SLOT_WIDTH'(HISTORY_DEPTH - 1);
   localparam logic [FILL_WIDTH-1:0] FULL_COUNT = FILL_WIDTH'(HISTORY_DEPTH);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_RESTART_ENABLE = 2'd0,
      CSR_BASE_MARGIN    = 2'd1,
      CSR_MARGIN_MIN     = 2'd2,
      CSR_MARGIN_MAX     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PATH_DISABLED    = 3'd0,
      PATH_ROOT_LEVEL  = 3'd1,
      PATH_BELOW_LIMIT = 3'd2,
      PATH_STABLE      = 3'd3,
      PATH_GLUE        = 3'd4
   } path_type;

endpackage

`default_nettype wire

FILE: rtl/glue_gradient_restart_decider_core.sv
`default_nettype none

// glue gradient restart decider: one restart check per transaction. a check answers
// "no restart" when restarts are disabled, at root level, or while the conflict count
// is below the limit; in stable mode it forwards the reluctant schedule's verdict;
// otherwise it keeps the last ten fast glue averages in a ring, takes the gradient
// against the oldest one, derives a margin (base minus 1.5x or 4x gradient, clamped to
// [margin_min, margin_max]) and restarts when fast glue exceeds slow glue times margin.
// throughput is one transaction per cycle while rsp_stall is low; a transaction passes
// through the input register and then the result register, with the gradient, clamp
// and 24x19 multiply-compare between them. the result register holds while rsp_stall
// is high, and req_stall rises only when both registers are occupied and stalled.
// csr writes are only allowed while no transaction is in flight.

module glue_gradient_restart_decider_core
   import ggrd_pkg::*;
(
   input  wire                           clock,
   input  wire                           reset,
   // configuration
   input  wire                           csr_write_enable,
   input  wire  [CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire  [MARGIN_WIDTH-1:0]       csr_write_data,
   // request channel
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [GLUE_WIDTH-1:0]         req_fast_glue,
   input  wire  [GLUE_WIDTH-1:0]         req_slow_glue,
   input  wire  [COUNT_WIDTH-1:0]        req_conflict_count,
   input  wire  [COUNT_WIDTH-1:0]        req_restart_limit,
   input  wire                           req_level_nonzero,
   input  wire                           req_stable_mode,
   input  wire                           req_reluctant_fire,
   // response channel
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_do_restart,
   output logic [2:0]                    rsp_decision_path,
   output logic [MARGIN_WIDTH-1:0]       rsp_margin_used
);

   // configuration registers
   logic                    restart_enable_ff;
   logic [MARGIN_WIDTH-1:0] base_margin_ff;
   logic [MARGIN_WIDTH-1:0] margin_min_ff;
   logic [MARGIN_WIDTH-1:0] margin_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_enable_ff <= 1'b1;
         base_margin_ff    <= BASE_MARGIN_RESET;
         margin_min_ff     <= MARGIN_MIN_RESET;
         margin_max_ff     <= MARGIN_MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESTART_ENABLE: restart_enable_ff <= csr_write_data[0];
            CSR_BASE_MARGIN:    base_margin_ff    <= csr_write_data;
            CSR_MARGIN_MIN:     margin_min_ff     <= csr_write_data;
            CSR_MARGIN_MAX:     margin_max_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic req_take;

   // output register is free or being drained this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   logic [GLUE_WIDTH-1:0]  fast_ff;
   logic [GLUE_WIDTH-1:0]  slow_ff;
   logic [COUNT_WIDTH-1:0] conflicts_ff;
   logic [COUNT_WIDTH-1:0] limit_ff;
   logic                   level_nz_ff;
   logic                   stable_ff;
   logic                   reluctant_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         fast_ff      <= req_fast_glue;
         slow_ff      <= req_slow_glue;
         conflicts_ff <= req_conflict_count;
         limit_ff     <= req_restart_limit;
         level_nz_ff  <= req_level_nonzero;
         stable_ff    <= req_stable_mode;
         reluctant_ff <= req_reluctant_fire;
      end
   end

   // fast glue history ring
   logic [GLUE_WIDTH-1:0] history_ff [HISTORY_DEPTH];
   logic [SLOT_WIDTH-1:0] write_slot_ff;
   logic [SLOT_WIDTH-1:0] write_slot_in;
   logic [FILL_WIDTH-1:0] fill_count_ff;
   logic [FILL_WIDTH-1:0] fill_count_in;
   logic                  ring_update;

   // gate evaluation, first match wins
   path_type path;
   always_comb begin
      priority if (!restart_enable_ff) begin
         path = PATH_DISABLED;
      end else if (!level_nz_ff) begin
         path = PATH_ROOT_LEVEL;
      end else if (conflicts_ff < limit_ff) begin
         path = PATH_BELOW_LIMIT;
      end else if (stable_ff) begin
         path = PATH_STABLE;
      end else begin
         path = PATH_GLUE;
      end
   end

   assign ring_update = advance && s1_valid_ff && (path == PATH_GLUE);

   // oldest value: current one when empty, first entry while filling, else next victim
   logic [GLUE_WIDTH-1:0] oldest;
   always_comb begin
      priority if (fill_count_ff == '0) begin
         oldest = fast_ff;
      end else if (fill_count_ff < FULL_COUNT) begin
         oldest = history_ff[0];
      end else begin
         oldest = history_ff[write_slot_ff];
      end
   end

   always_comb begin
      write_slot_in = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
      fill_count_in = (fill_count_ff == FULL_COUNT) ? fill_count_ff : fill_count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_count_ff <= '0;
      end else if (ring_update) begin
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_update) begin
         history_ff[write_slot_ff] <= fast_ff;
      end
   end

   // margin in Q2.17 so the 1.5x slope stays exact
   logic signed [GRAD_WIDTH-1:0]   grad;
   logic signed [M2_WIDTH-1:0]     grad_ext;
   logic signed [M2_WIDTH-1:0]     slope_term;
   logic signed [M2_WIDTH-1:0]     base2;
   logic signed [M2_WIDTH-1:0]     lo2;
   logic signed [M2_WIDTH-1:0]     hi2;
   logic signed [M2_WIDTH-1:0]     m2_raw;
   logic signed [M2_WIDTH-1:0]     m2_lo;
   logic signed [M2_WIDTH-1:0]     m2;
   logic                           grad_pos;
   logic [M2_MAG_WIDTH-1:0]        m2_mag;
   logic [PROD_WIDTH-1:0]          slow_scaled;
   logic [PROD_WIDTH-1:0]          fast_scaled;
   logic                           glue_fire;

   always_comb begin
      grad     = $signed({1'b0, fast_ff}) - $signed({1'b0, oldest});
      grad_ext = {{(M2_WIDTH - GRAD_WIDTH){grad[GRAD_WIDTH-1]}}, grad};
      grad_pos = !grad[GRAD_WIDTH-1] && (grad != '0);
      // 3g for a rising gradient, 8g otherwise (4x in Q2.16)
      slope_term = grad_pos ? ((grad_ext <<< 1) + grad_ext) : (grad_ext <<< 3);
      base2  = $signed({{(M2_WIDTH - MARGIN_WIDTH - 1){1'b0}}, base_margin_ff, 1'b0});
      lo2    = $signed({{(M2_WIDTH - MARGIN_WIDTH - 1){1'b0}}, margin_min_ff, 1'b0});
      hi2    = $signed({{(M2_WIDTH - MARGIN_WIDTH - 1){1'b0}}, margin_max_ff, 1'b0});
      m2_raw = base2 - slope_term;
      // lower clamp first, upper clamp wins when the bounds cross
      m2_lo  = (m2_raw < lo2) ? lo2 : m2_raw;
      m2     = (m2_lo > hi2) ? hi2 : m2_lo;
      // clamped value is non-negative and below 2^19
      m2_mag = m2[M2_MAG_WIDTH-1:0];
      slow_scaled = PROD_WIDTH'(slow_ff) * PROD_WIDTH'(m2_mag);
      fast_scaled = PROD_WIDTH'({fast_ff, {(MARGIN_FRAC + 1){1'b0}}});
      glue_fire   = fast_scaled > slow_scaled;
   end

   // result register
   logic                    do_restart_ff;
   logic                    do_restart_in;
   path_type                path_ff;
   logic [MARGIN_WIDTH-1:0] margin_ff;
   logic [MARGIN_WIDTH-1:0] margin_in;

   always_comb begin
      do_restart_in = 1'b0;
      margin_in     = '0;
      unique case (path)
         PATH_STABLE: begin
            do_restart_in = reluctant_ff;
         end
         PATH_GLUE: begin
            do_restart_in = glue_fire;
            margin_in     = m2_mag[M2_MAG_WIDTH-1:1];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         do_restart_ff <= do_restart_in;
         path_ff       <= path;
         margin_ff     <= margin_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_do_restart    = do_restart_ff;
   assign rsp_decision_path = path_ff;
   assign rsp_margin_used   = margin_ff;

endmodule

`default_nettype wire

FILE: test/glue_gradient_restart_decider_core_tb.sv
module glue_gradient_restart_decider_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ggrd_pkg::*;

   // run shape
   localparam int CYCLE_LIMIT     = 600000;  // far above the slowest legal run
   localparam int ITEMS_PER_PHASE = 172;     // nine register phases of random checks
   localparam int FIXED_COUNT     = 7;
   localparam int PHASE_COUNT     = 9;
   localparam int DIRECTED_COUNT  = 22;
   localparam int PRINT_LIMIT     = 30;
   localparam int SETTLE_CYCLES   = 10;      // room for the input and result registers plus slack

   localparam logic [GLUE_WIDTH-1:0]  GLUE_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // one restart check as the sender presents it
   typedef struct packed {
      logic [GLUE_WIDTH-1:0]  fast;
      logic [GLUE_WIDTH-1:0]  slow;
      logic [COUNT_WIDTH-1:0] conflicts;
      logic [COUNT_WIDTH-1:0] limit;
      logic                   level_nz;
      logic                   stable;
      logic                   reluctant;
   } check_type;

   // the decision the block should come back with
   typedef struct packed {
      logic                    restart;
      path_type                path;
      logic [MARGIN_WIDTH-1:0] margin;
   } verdict_type;

   // a directed row: the check, and a hand-written verdict where typed is set
   typedef struct packed {
      check_type   chk;
      logic        typed;
      verdict_type want;
   } row_type;

   // one full set of register values
   typedef struct packed {
      logic                    en;
      logic [MARGIN_WIDTH-1:0] base;
      logic [MARGIN_WIDTH-1:0] lo;
      logic [MARGIN_WIDTH-1:0] hi;
   } regs_type;

   // directed checks, all under the reset register values
   localparam row_type DIRECTED [DIRECTED_COUNT] = '{
      // root level wins over every later gate
      '{'{GLUE_MAX, 24'd0, COUNT_MAX, 48'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b0, PATH_ROOT_LEVEL, 18'd0}},
      // far below the conflict limit
      '{'{24'd0, GLUE_MAX, 48'd0, COUNT_MAX, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{1'b0, PATH_BELOW_LIMIT, 18'd0}},
      // one short of the limit beats stable mode
      '{'{GLUE_MAX, GLUE_MAX, 48'd99, 48'd100, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, PATH_BELOW_LIMIT, 18'd0}},
      // stable mode passes the reluctant verdict through
      '{'{24'd0, 24'd0, COUNT_MAX, COUNT_MAX, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b1, PATH_STABLE, 18'd0}},
      '{'{GLUE_MAX, 24'd0, COUNT_MAX, 48'd0, 1'b1, 1'b1, 1'b0}, 1'b1,
        '{1'b0, PATH_STABLE, 18'd0}},
      '{'{24'd0, 24'd0, 48'd0, COUNT_MAX, 1'b0, 1'b1, 1'b1}, 1'b1,
        '{1'b0, PATH_ROOT_LEVEL, 18'd0}},
      // first glue check ever: gradient is zero, so the margin is the base
      '{'{24'd0, 24'd0, 48'd7, 48'd7, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{1'b0, PATH_GLUE, 18'd68813}},
      // steepest rise while filling: margin pinned at the lower clamp
      '{'{GLUE_MAX, GLUE_MAX, COUNT_MAX, COUNT_MAX, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{1'b1, PATH_GLUE, 18'd52429}},
      // ring still filling, oldest stays the first value written
      '{'{24'd0, GLUE_MAX, 48'd1, 48'd0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // odd gradient: the 1.5 factor leaves a half lsb that must be floored
      '{'{24'd1, 24'd0, 48'd2, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'h010000, 24'h00F000, 48'd3, 48'd1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{24'h000003, 24'h000002, 48'd4, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'h0F0000, 24'h0E0000, 48'd5, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'h800000, 24'h7FFFFF, 48'd6, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'h123456, 24'h654321, 48'd7, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // tenth glue check fills the ring
      '{'{24'h00FFFF, 24'h00F333, 48'd8, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // full ring: oldest is the slot about to be overwritten
      '{'{24'h000800, 24'h000780, 48'd9, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // steep fall against the stored maximum: margin pinned at the upper clamp
      '{'{24'h000010, 24'h000001, 48'd10, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'h00FFFF, 24'h00FFFF, 48'd11, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{24'd0, 24'd0, 48'd12, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // stable check in between must leave the ring alone
      '{'{GLUE_MAX, 24'd1, 48'd13, 48'd1, 1'b1, 1'b1, 1'b0}, 1'b1,
        '{1'b0, PATH_STABLE, 18'd0}},
      '{'{24'd2, 24'd1, 48'd14, 48'd1, 1'b1, 1'b0, 1'b0}, 1'b0, '0}
   };

   // register phases: defaults, disabled, extremes, crossed clamps, open clamps
   localparam regs_type FIXED_SETTINGS [FIXED_COUNT] = '{
      '{1'b1, 18'd68813, 18'd52429, 18'd163840},
      '{1'b0, 18'd68813, 18'd52429, 18'd163840},
      '{1'b1, 18'd0, 18'd0, 18'd0},
      '{1'b1, 18'd262143, 18'd262143, 18'd262143},
      '{1'b1, 18'd100000, 18'd150000, 18'd60000},
      '{1'b1, 18'd0, 18'd0, 18'd262143},
      '{1'b1, 18'd262143, 18'd0, 18'd262143}
   };

   // dut connections, inputs all known from time zero
   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     csr_write_enable   = 1'b0;
   csr_index_type            csr_index          = CSR_RESTART_ENABLE;
   logic [MARGIN_WIDTH-1:0]  csr_write_data     = '0;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic [GLUE_WIDTH-1:0]    req_fast_glue      = '0;
   logic [GLUE_WIDTH-1:0]    req_slow_glue      = '0;
   logic [COUNT_WIDTH-1:0]   req_conflict_count = '0;
   logic [COUNT_WIDTH-1:0]   req_restart_limit  = '0;
   logic                     req_level_nonzero  = 1'b0;
   logic                     req_stable_mode    = 1'b0;
   logic                     req_reluctant_fire = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic                     rsp_do_restart;
   logic [2:0]               rsp_decision_path;
   logic [MARGIN_WIDTH-1:0]  rsp_margin_used;

   // predictor copy of the registers and the fast glue ring
   logic                     cfg_enable = 1'b1;
   logic [MARGIN_WIDTH-1:0]  cfg_base   = BASE_MARGIN_RESET;
   logic [MARGIN_WIDTH-1:0]  cfg_lo     = MARGIN_MIN_RESET;
   logic [MARGIN_WIDTH-1:0]  cfg_hi     = MARGIN_MAX_RESET;
   logic [GLUE_WIDTH-1:0]    ring [HISTORY_DEPTH];
   int                       slot = 0;
   int                       fill = 0;

   verdict_type verdicts_due[$];     // one per accepted check, oldest first
   int       mismatch_count = 0;
   int       cycle_count    = 0;
   bit       calm           = 1'b0;  // no random gaps or stall runs on either side while set
   longint   glue_walk      = 64'h030000;  // slowly drifting fast glue

   glue_gradient_restart_decider_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_fast_glue      (req_fast_glue),
      .req_slow_glue      (req_slow_glue),
      .req_conflict_count (req_conflict_count),
      .req_restart_limit  (req_restart_limit),
      .req_level_nonzero  (req_level_nonzero),
      .req_stable_mode    (req_stable_mode),
      .req_reluctant_fire (req_reluctant_fire),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_do_restart     (rsp_do_restart),
      .rsp_decision_path  (rsp_decision_path),
      .rsp_margin_used    (rsp_margin_used)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // idle stretch length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 50);
   endfunction

   // predictor: gates in order, then the ring, gradient, clamp and compare
   function automatic verdict_type decide_restart(check_type c);
      verdict_type           v;
      logic [GLUE_WIDTH-1:0] oldest;
      longint                grad, m2, lo2, hi2;
      v = '{1'b0, PATH_GLUE, '0};
      if (!cfg_enable) begin
         v.path = PATH_DISABLED;
      end else if (!c.level_nz) begin
         v.path = PATH_ROOT_LEVEL;
      end else if (c.conflicts < c.limit) begin
         v.path = PATH_BELOW_LIMIT;
      end else if (c.stable) begin
         v.path    = PATH_STABLE;
         v.restart = c.reluctant;
      end else begin
         // first use compares against itself, filling compares against slot 0
         if (fill == 0) oldest = c.fast;
         else if (fill < HISTORY_DEPTH) oldest = ring[0];
         else oldest = ring[slot];
         ring[slot] = c.fast;
         slot = (slot == HISTORY_DEPTH - 1) ? 0 : slot + 1;
         if (fill < HISTORY_DEPTH) fill++;
         // margin kept at twice the q2.16 scale so the 1.5 factor is exact
         grad = longint'(c.fast) - longint'(oldest);
         m2   = 2 * longint'(cfg_base);
         if (grad > 0) m2 = m2 - 3 * grad;
         else m2 = m2 - 8 * grad;
         lo2 = 2 * longint'(cfg_lo);
         hi2 = 2 * longint'(cfg_hi);
         // lower clamp first, so crossed clamps end at the upper one
         if (m2 < lo2) m2 = lo2;
         if (m2 > hi2) m2 = hi2;
         v.restart = (longint'(c.fast) <<< 17) > (longint'(c.slow) * m2);
         v.margin  = m2[MARGIN_WIDTH:1];
      end
      return v;
   endfunction

   // random check: mostly reaches the glue compare, with a drifting fast average
   function automatic check_type random_check();
      check_type              c;
      logic [COUNT_WIDTH-1:0] p, q, lo_c, hi_c;
      longint                 scaled;
      int                     kind, pick;
      p = COUNT_WIDTH'({$urandom, $urandom});
      q = COUNT_WIDTH'({$urandom, $urandom});
      if ($urandom_range(0, 15) == 0) q = p;
      lo_c = (p < q) ? p : q;
      hi_c = (p < q) ? q : p;
      kind = $urandom_range(0, 99);
      c.reluctant = 1'($urandom_range(0, 1));
      c.level_nz  = (kind >= 8);
      c.stable    = (kind >= 8 && kind < 18);
      if (kind < 8) begin
         c.conflicts = p;
         c.limit     = q;
      end else if (kind >= 18 && kind < 28) begin
         c.conflicts = lo_c;
         c.limit     = hi_c;
      end else begin
         c.conflicts = hi_c;
         c.limit     = lo_c;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         c.fast = GLUE_WIDTH'($urandom);
      end else if (pick == 1) begin
         c.fast = $urandom_range(0, 1) ? GLUE_MAX : GLUE_WIDTH'($urandom_range(0, 15));
      end else begin
         if ($urandom_range(0, 19) == 0)
            glue_walk = glue_walk + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         else
            glue_walk = glue_walk + longint'($urandom_range(0, 4000)) - 2000;
         if (glue_walk < 0) glue_walk = 0;
         if (glue_walk > longint'(GLUE_MAX)) glue_walk = longint'(GLUE_MAX);
         c.fast = glue_walk[GLUE_WIDTH-1:0];
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         c.slow = GLUE_WIDTH'($urandom);
      end else if (pick == 1) begin
         c.slow = $urandom_range(0, 1) ? GLUE_MAX : GLUE_WIDTH'($urandom_range(0, 15));
      end else begin
         // slow near fast so the compare lands on both sides of the margin
         scaled = longint'(c.fast) * longint'($urandom_range(60, 160)) / 100;
         if (scaled > longint'(GLUE_MAX)) scaled = longint'(GLUE_MAX);
         c.slow = scaled[GLUE_WIDTH-1:0];
      end
      return c;
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want,
                  cycle_count);
   endtask

   // present one check, hold it until accepted, then queue its verdict
   task automatic send_check(input check_type c, input logic typed,
                             input verdict_type want);
      int          gap;
      verdict_type guess;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_fast_glue      <= c.fast;
      req_slow_glue      <= c.slow;
      req_conflict_count <= c.conflicts;
      req_restart_limit  <= c.limit;
      req_level_nonzero  <= c.level_nz;
      req_stable_mode    <= c.stable;
      req_reluctant_fire <= c.reluctant;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      // predictor always runs so the ring stays in step with typed rows too
      guess = decide_restart(c);
      verdicts_due.push_back(typed ? want : guess);
   endtask

   // stop sending and wait for every outstanding verdict
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_due.size() != 0);
   endtask

   // write all four registers back to back, block idle
   task automatic program_regs(input regs_type s, input logic [MARGIN_WIDTH-2:0] junk);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RESTART_ENABLE;
      csr_write_data   <= {junk, s.en};
      @(posedge clock);
      cfg_enable = s.en;
      csr_index      <= CSR_BASE_MARGIN;
      csr_write_data <= s.base;
      @(posedge clock);
      cfg_base = s.base;
      csr_index      <= CSR_MARGIN_MIN;
      csr_write_data <= s.lo;
      @(posedge clock);
      cfg_lo = s.lo;
      csr_index      <= CSR_MARGIN_MAX;
      csr_write_data <= s.hi;
      @(posedge clock);
      cfg_hi = s.hi;
      csr_write_enable <= 1'b0;
   endtask

   // result side: check each accepted transaction, stall in random runs
   int stall_run = 0;
   bit stall_on  = 1'b0;

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            flag_mismatch("result with nothing pending", 1, 0);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_do_restart !== want.restart)
               flag_mismatch("do_restart", rsp_do_restart, want.restart);
            if (rsp_decision_path !== want.path)
               flag_mismatch("decision_path", rsp_decision_path, want.path);
            if (rsp_margin_used !== want.margin)
               flag_mismatch("margin_used", rsp_margin_used, want.margin);
         end
      end
      if (stall_run == 0) begin
         stall_on  = !calm && ($urandom_range(0, 3) == 0);
         stall_run = stall_on ? idle_len() : $urandom_range(1, 12);
      end
      stall_run--;
      rsp_stall <= stall_on;
   end

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed checks under reset register values
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_check(DIRECTED[i].chk, DIRECTED[i].typed, DIRECTED[i].want);

      // random checks, one register setting per phase
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         regs_type s;
         if (ph < FIXED_COUNT)
            s = FIXED_SETTINGS[ph];
         else
            s = '{1'($urandom_range(0, 3) != 0), MARGIN_WIDTH'($urandom),
                  MARGIN_WIDTH'($urandom), MARGIN_WIDTH'($urandom)};
         wait_drain();
         // upper enable bits carry junk in the random phases only
         program_regs(s, (ph < FIXED_COUNT) ? '0 : (MARGIN_WIDTH - 1)'($urandom));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            // occasionally let the pipeline empty completely mid-phase
            if ($urandom_range(0, 299) == 0) wait_drain();
            send_check(random_check(), 1'b0, '0);
         end
      end

      wait_drain();
      // catch any stray extra result
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ggrd_pkg.sv
rtl/glue_gradient_restart_decider_core.sv
test/glue_gradient_restart_decider_core_tb.sv
